/* rtl/core/srpt_preemptive_scheduler_top_assert.svh */
// assertion macros for the scheduler checker
// no dependencies; included by the checker file
`ifndef SRPT_PREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH
`define SRPT_PREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRPT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SRPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/srpt_pkg.sv */
// shared types, widths and helpers for the srpt scheduler
// no dependencies
package srpt_pkg;

	localparam int MAX_JOBS_DEF = 256;
	localparam int ID_W         = 16;
	localparam int START_W      = 16;
	localparam int SIZE_W       = 16;
	localparam int NOW_W        = 32;
	localparam int SUM_W        = 40;

	// saturation limit of the completion sum (all ones)
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic {
		MODE_ADD  = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [ID_W-1:0]    job_id;
		logic [START_W-1:0] job_start;
		logic [SIZE_W-1:0]  job_size;
	} item_t;

	typedef struct packed {
		logic               table_full;
		logic               served;
		logic [ID_W-1:0]    served_id;
		logic               job_finished;
		logic               all_done;
		logic [SUM_W-1:0]   completion_sum;
		logic [NOW_W-1:0]   now_time;
	} result_t;

	// one job table entry
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  left;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic busy;
		logic done;
	} ctrl_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_PLACE,
		ST_SCAN,
		ST_SERVE,
		ST_DONE
	} state_t;

	// stored entry stays in front of a new job with this start and size
	function automatic logic precedes(entry_t e, logic [START_W-1:0] start,
			logic [SIZE_W-1:0] size);
		return (e.start < start) || ((e.start == start) && (e.left < size));
	endfunction

endpackage

/* rtl/core/srpt_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module srpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/srpt_ctrl.sv */
// sequencer for the srpt scheduler: insert search and shift, tick scan and serve
// depends on srpt_pkg; drives the job table ram
module srpt_ctrl import srpt_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF,
	localparam int IDX_W = $clog2(MAX_JOBS),
	localparam int CNT_W = $clog2(MAX_JOBS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	input  logic             out_free,
	output ctrl_status_t     status,
	output result_t          result,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_data,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   pending_q, pending_d;
	logic [NOW_W-1:0]   time_q, time_d;
	logic [SUM_W-1:0]   total_q, total_d;
	logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]   remain_q, remain_d;
	logic               rd_s1, rd_s1_d;
	logic [IDX_W-1:0]   rd_addr_s1;
	logic               found_q, found_d;
	logic               full_q, full_d;
	logic               served_q, served_d;
	logic               fin_q, fin_d;
	item_t              item_q, item_d;
	logic [IDX_W-1:0]   pos_q, pos_d;
	entry_t             best_q, best_d;
	logic [IDX_W-1:0]   best_idx_q, best_idx_d;
	logic [ID_W-1:0]    sid_q, sid_d;

	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   last_idx;
	logic               hit;
	logic               eligible;
	logic               better;
	logic [NOW_W-1:0]   time_nx;
	logic [SUM_W:0]     sum_w;
	logic [SUM_W-1:0]   total_sat;

	// index of the last stored entry
	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];

	// insert search: first entry that does not stay in front of the new job
	assign hit = rd_s1 && !precedes(rd_data, item_q.job_start, item_q.job_size);

	// tick scan: released, unfinished, and no worse than the best so far
	assign eligible = (rd_data.left != '0) && (NOW_W'(rd_data.start) <= time_q);
	assign better   = eligible && (!found_q || (rd_data.left <= best_q.left));

	// time advance and saturating completion sum
	assign time_nx   = time_q + NOW_W'(1);
	assign sum_w     = (SUM_W + 1)'(total_q) + (SUM_W + 1)'(time_nx);
	assign total_sat = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];

	// next state and memory requests
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pending_d  = pending_q;
		time_d     = time_q;
		total_d    = total_q;
		rd_ptr_d   = rd_ptr_q;
		remain_d   = remain_q;
		rd_s1_d    = 1'b0;
		found_d    = found_q;
		full_d     = full_q;
		served_d   = served_q;
		fin_d      = fin_q;
		item_d     = item_q;
		pos_d      = pos_q;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		sid_d      = sid_q;
		rd_en      = 1'b0;
		rd_addr    = rd_ptr_q[IDX_W-1:0];
		wr_en      = 1'b0;
		wr_addr    = rd_addr_s1 + IDX_W'(1);
		wr_data    = rd_data;
		status.busy = (state_q != ST_IDLE);
		status.done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_d   = item;
					full_d   = 1'b0;
					served_d = 1'b0;
					fin_d    = 1'b0;
					sid_d    = '0;
					rd_ptr_d = '0;
					found_d  = 1'b0;
					if (item.mode == MODE_ADD) begin
						if (count_q == CNT_W'(MAX_JOBS)) begin
							full_d  = 1'b1;
							state_d = ST_DONE;
						end else if (count_q == '0) begin
							pos_d   = '0;
							state_d = ST_PLACE;
						end else begin
							state_d = ST_SEARCH;
						end
					end else if (pending_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					pos_d    = rd_addr_s1;
					rd_ptr_d = cnt_m1;
					remain_d = count_q - CNT_W'(rd_addr_s1);
					state_d  = ST_SHIFT;
				end else begin
					if (rd_s1 && (rd_addr_s1 == last_idx)) begin
						pos_d   = count_q[IDX_W-1:0];
						state_d = ST_PLACE;
					end
					if (rd_ptr_q < count_q) begin
						rd_en    = 1'b1;
						rd_s1_d  = 1'b1;
						rd_ptr_d = rd_ptr_q + CNT_W'(1);
					end
				end
			end
			ST_SHIFT: begin
				// read entry k-1 and write it back one place higher
				if (remain_q != '0) begin
					rd_en    = 1'b1;
					rd_s1_d  = 1'b1;
					rd_ptr_d = rd_ptr_q - CNT_W'(1);
					remain_d = remain_q - CNT_W'(1);
				end
				if (rd_s1) begin
					wr_en = 1'b1;
					if (rd_addr_s1 == pos_q) begin
						state_d = ST_PLACE;
					end
				end
			end
			ST_PLACE: begin
				wr_en      = 1'b1;
				wr_addr    = pos_q;
				wr_data.id    = item_q.job_id;
				wr_data.start = item_q.job_start;
				wr_data.left  = item_q.job_size;
				count_d    = count_q + CNT_W'(1);
				if (item_q.job_size != '0) begin
					pending_d = pending_q + CNT_W'(1);
				end
				state_d    = ST_DONE;
			end
			ST_SCAN: begin
				if (rd_ptr_q < count_q) begin
					rd_en    = 1'b1;
					rd_s1_d  = 1'b1;
					rd_ptr_d = rd_ptr_q + CNT_W'(1);
				end
				if (rd_s1) begin
					if (better) begin
						best_d     = rd_data;
						best_idx_d = rd_addr_s1;
						found_d    = 1'b1;
					end
					if (rd_addr_s1 == last_idx) begin
						state_d = ST_SERVE;
					end
				end
			end
			ST_SERVE: begin
				time_d = time_nx;
				if (found_q) begin
					wr_en        = 1'b1;
					wr_addr      = best_idx_q;
					wr_data      = best_q;
					wr_data.left = best_q.left - SIZE_W'(1);
					served_d     = 1'b1;
					sid_d        = best_q.id;
					if (best_q.left == SIZE_W'(1)) begin
						fin_d     = 1'b1;
						pending_d = pending_q - CNT_W'(1);
						total_d   = total_sat;
					end
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					status.done = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pending_q <= '0;
			time_q    <= '0;
			total_q   <= '0;
			rd_ptr_q  <= '0;
			remain_q  <= '0;
			rd_s1     <= 1'b0;
			found_q   <= 1'b0;
			full_q    <= 1'b0;
			served_q  <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			pending_q <= pending_d;
			time_q    <= time_d;
			total_q   <= total_d;
			rd_ptr_q  <= rd_ptr_d;
			remain_q  <= remain_d;
			rd_s1     <= rd_s1_d;
			found_q   <= found_d;
			full_q    <= full_d;
			served_q  <= served_d;
			fin_q     <= fin_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_ptr_q[IDX_W-1:0];
		item_q     <= item_d;
		pos_q      <= pos_d;
		best_q     <= best_d;
		best_idx_q <= best_idx_d;
		sid_q      <= sid_d;
	end

	// result fields, settled once in the done state
	assign result.table_full     = full_q;
	assign result.served         = served_q;
	assign result.served_id      = sid_q;
	assign result.job_finished   = fin_q;
	assign result.all_done       = (pending_q == '0);
	assign result.completion_sum = total_q;
	assign result.now_time       = time_q;

endmodule

/* rtl/core/srpt_preemptive_scheduler_top.sv */
// Shortest-remaining-time scheduler with a job table in one ram.
// Channels: item (item_valid / item_stall / item) carries add or tick commands,
// result (result_valid / result_stall / result) returns one result per item.
// A transfer happens at a clock edge where valid is high and stall is low.
// One item is worked at a time; item_stall is high from the accepting edge
// until the result has been moved into the output register.
// A tick does one ram read per entry for the minimum search, then one write
// back of the chosen entry if a released job was found. An add does a read
// pass to find the slot, then a read/write pass shifting the later entries up
// one place; the two passes read each entry once, the slot entry twice.
// A full-table add or a tick with all jobs done goes straight to done.
// The output register lets the next item be accepted while a result waits;
// while result_stall is high the result holds and the block finishes at most
// one more item before it waits as well.
// Reset (arst_n low) empties the table, clears time and the completion sum;
// table contents need no clearing since only entries below the count are read.
module srpt_preemptive_scheduler_top import srpt_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IDX_W = $clog2(MAX_JOBS);

	ctrl_status_t     status;
	result_t          ctrl_result;
	logic             out_free;
	logic             accept;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             result_valid_q;
	result_t          result_q;

	// input side: one item in flight
	assign item_stall = status.busy;
	assign accept     = item_valid && !item_stall;

	// output register can take a new result
	assign out_free = !result_valid_q || !result_stall;

	srpt_ctrl #(
		.MAX_JOBS (MAX_JOBS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.item     (item),
		.out_free (out_free),
		.status   (status),
		.result   (ctrl_result),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	srpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_JOBS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (status.done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (status.done) begin
			result_q <= ctrl_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/srpt_checker.sv */
// port-level checks for the srpt scheduler, bound to the top level
// depends on srpt_pkg and srpt_preemptive_scheduler_top_assert.svh
`include "srpt_preemptive_scheduler_top_assert.svh"

module srpt_checker import srpt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// one item at a time: an accepted item closes the input
	`SRPT_ASSERT_NEXT(a_stall_after_accept, clk, arst_n,
		item_valid && !item_stall, item_stall, "input not stalled after transfer")

	// a stalled result stays put
	`SRPT_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result), "stalled result changed")

	// a finish only comes with a served unit
	`SRPT_ASSERT_SAME(a_fin_served, clk, arst_n, result_valid && result.job_finished,
		result.served, "finish without service")

	// a dropped add never serves anything
	`SRPT_ASSERT_SAME(a_full_alone, clk, arst_n, result_valid && result.table_full,
		!result.served && !result.job_finished && (result.served_id == '0),
		"table full with service")

endmodule

bind srpt_preemptive_scheduler_top srpt_checker u_srpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
